// ===== rtl/bia_pkg.sv =====
// ----------------------------------------------------------------------------
// bia_pkg
// Shared sizes, codes and types of the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

    // Number of managed identifiers and the width of one bitmap word.
    // WORD_BITS must be a power of two.
    localparam int ID_COUNT  = 4096;
    localparam int WORD_BITS = 32;
    localparam int ID_W      = 16;

    // Derived bitmap geometry.
    localparam int MAP_WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int TAIL_BITS = ID_COUNT - (MAP_WORDS - 1) * WORD_BITS;

    // Bits of the last word that lie beyond the managed range read as used.
    localparam logic [WORD_BITS-1:0] TAIL_MASK =
        ~((WORD_BITS'(1) << TAIL_BITS) - WORD_BITS'(1));

    // Identifier that index zero maps to after reset.
    localparam logic [ID_W-1:0] BASE_RESET = 16'd300;

    // Request kinds carried in the input tuser.
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Result status carried in the output tuser.
    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_FULL     = 2'd1,
        ST_RELEASED = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REL,
        S_HOLD
    } t_state;

endpackage

// ===== rtl/bitmap_id_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Lowest-free-first identifier allocator over a bitmap kept in block memory.
//
// The slave stream takes one request at a time: tuser selects allocate (0) or
// release (1), tdata carries the identifier to release. The master stream
// returns exactly one result per request: tdata is the granted identifier
// (zero unless granted), tuser the status code.
// An allocate scans the bitmap one word per cycle from word zero up to the
// first word with a free bit, then moves to the hold state, which loads the
// output register; with every identifier used it reports full at the last
// word. A release goes through the release state to the hold state, an
// out-of-range release straight to the hold state. The next request is taken
// in the cycle after the result is loaded. The user must write the base
// identifier only while no request is in flight; the block does not enforce it.
// Reset clears the per-word valid bits, so the whole map reads as free at
// once. A stalled receiver holds the result in the output register; a finished
// result then waits in the sequencer and no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module bitmap_id_allocator
    import bia_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    // Configuration: base identifier.
    input  logic            i_cfg_wr_en,
    input  logic [ID_W-1:0] i_cfg_wr_data,
    // Request stream.
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [ID_W-1:0] i_s_axis_tdata,   // [15:0] release_id
    input  logic            i_s_axis_tuser,   // [0] mode
    // Result stream.
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [ID_W-1:0] o_m_axis_tdata,   // [15:0] granted_id
    output logic [1:0]      o_m_axis_tuser    // [1:0] status
);

    // Bitmap memory with one valid bit per word; an invalid word reads as free.
    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_vld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [ID_W-1:0]      r_base_id;
    logic [ID_W-1:0]      r_res_id, n_res_id;
    t_status              r_res_status, n_res_status;
    logic                 r_out_valid;
    logic [ID_W-1:0]      r_out_id;
    t_status              r_out_status;

    logic [ADDR_W-1:0]    rd_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] wr_data;
    logic                 load_out;
    logic [WORD_BITS-1:0] word_raw;
    logic [WORD_BITS-1:0] word_eff;
    logic [BIT_W-1:0]     free_bit;
    logic [ID_W-1:0]      rel_idx;
    logic                 rel_ok;

    // Position of the lowest clear bit of a word.
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // Memory write and registered read. The sequencer never uses a word read in
    // the cycle it writes one, so no forwarding path is needed.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

    // Valid bits: cleared at reset, set on the first write of a word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[r_addr] <= 1'b1;
        end
    end

    // Base identifier register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id <= BASE_RESET;
        end else if (i_cfg_wr_en) begin
            r_base_id <= i_cfg_wr_data;
        end
    end

    // Word as read, with the bits past the managed range forced used.
    assign word_raw = r_rd_vld ? r_rd_data : '0;
    assign word_eff = (r_addr == ADDR_W'(MAP_WORDS - 1)) ? (word_raw | TAIL_MASK) : word_raw;
    assign free_bit = first_zero(word_eff);

    // Map a release identifier back to its bitmap index.
    assign rel_idx = i_s_axis_tdata - r_base_id;
    assign rel_ok  = ({1'b0, rel_idx} < 17'(ID_COUNT));

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the request in flight.
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_bit        <= n_bit;
        r_res_id     <= n_res_id;
        r_res_status <= n_res_status;
    end

    // Next state, memory control and result capture.
    always_comb begin
        n_state         = r_state;
        n_addr          = r_addr;
        n_bit           = r_bit;
        n_res_id        = r_res_id;
        n_res_status    = r_res_status;
        rd_addr         = r_addr;
        mem_we          = 1'b0;
        wr_data         = word_raw;
        load_out        = 1'b0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (i_s_axis_tuser == MODE_ALLOC) begin
                        rd_addr = '0;
                        n_addr  = '0;
                        n_state = S_SCAN;
                    end else if (rel_ok) begin
                        rd_addr = ADDR_W'(rel_idx >> BIT_W);
                        n_addr  = ADDR_W'(rel_idx >> BIT_W);
                        n_bit   = rel_idx[BIT_W-1:0];
                        n_state = S_REL;
                    end else begin
                        n_res_id     = '0;
                        n_res_status = ST_INVALID;
                        n_state      = S_HOLD;
                    end
                end
            end
            S_SCAN: begin
                if (word_eff != '1) begin
                    mem_we       = 1'b1;
                    wr_data      = word_raw | (WORD_BITS'(1) << free_bit);
                    n_res_id     = ID_W'(32'(r_base_id) + (32'(r_addr) << BIT_W)
                                         + 32'(free_bit));
                    n_res_status = ST_GRANTED;
                    n_state      = S_HOLD;
                end else if (r_addr == ADDR_W'(MAP_WORDS - 1)) begin
                    n_res_id     = '0;
                    n_res_status = ST_FULL;
                    n_state      = S_HOLD;
                end else begin
                    rd_addr = r_addr + ADDR_W'(1);
                    n_addr  = r_addr + ADDR_W'(1);
                end
            end
            S_REL: begin
                mem_we       = 1'b1;
                wr_data      = word_raw & ~(WORD_BITS'(1) << r_bit);
                n_res_id     = '0;
                n_res_status = ST_RELEASED;
                n_state      = S_HOLD;
            end
            S_HOLD: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_id     <= r_res_id;
            r_out_status <= r_res_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_id;
    assign o_m_axis_tuser  = r_out_status;

endmodule

// ===== rtl/bia_checker.sv =====
// ----------------------------------------------------------------------------
// bia_checker
// Port-level checks of the bitmap identifier allocator, bound to the top.
// ----------------------------------------------------------------------------
module bia_checker
    import bia_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_s_axis_tvalid,
    input logic            o_s_axis_tready,
    input logic            o_m_axis_tvalid,
    input logic            i_m_axis_tready,
    input logic [ID_W-1:0] o_m_axis_tdata,
    input logic [1:0]      o_m_axis_tuser
);

    // A stalled result holds its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // Only a grant carries a nonzero identifier.
    a_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_GRANTED) |-> o_m_axis_tdata == '0)
        else $error("nonzero identifier on a non-grant result");

    // One request at a time: no request is taken right after another.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while another is in flight");

    // A new result appears only while the request side is closed.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared without a request in flight");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);

// ===== sim/bitmap_id_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_id_allocator_tb
// Self-checking bench for the lowest-free-first identifier allocator. A
// directed table covers the range edges and the granted, released and
// invalid status codes after reset. Random phases follow under several base
// identifiers, including the lowest and the highest one. Every result is
// compared against a bit-level model of the bitmap kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bitmap_id_allocator_tb;
    import bia_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = MAP_WORDS + 8;

    typedef struct {
        logic [ID_W-1:0] granted_id;
        t_status         status;
    } t_result;

    typedef struct {
        logic            mode;
        logic [ID_W-1:0] id;
        bit              typed;
        logic [ID_W-1:0] exp_id;
        t_status         exp_status;
    } t_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_wr_en = 1'b0;
    logic [ID_W-1:0] i_cfg_wr_data = '0;
    logic            i_s_axis_tvalid = 1'b0;
    logic            o_s_axis_tready;
    logic [ID_W-1:0] i_s_axis_tdata = '0;
    logic            i_s_axis_tuser = MODE_ALLOC;
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready = 1'b0;
    logic [ID_W-1:0] o_m_axis_tdata;
    logic [1:0]      o_m_axis_tuser;

    // Bench copy of the allocator state.
    bit   [ID_COUNT-1:0] id_used = '0;
    logic [ID_W-1:0]     base_now = BASE_RESET;
    int                  used_total = 0;

    t_result pending_results[$];
    t_row    directed_rows[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    int      tx_max_gap = 13;
    int      rx_max_gap = 13;
    bit      hold_output = 1'b0;

    bitmap_id_allocator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    task report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    // Applies one request to the bench bitmap and returns the answer it must get.
    function automatic t_result next_alloc_result(input logic mode,
                                                  input logic [ID_W-1:0] rel);
        t_result         r;
        logic [ID_W-1:0] offset;
        r.granted_id = '0;
        if (mode == MODE_ALLOC) begin
            r.status = ST_FULL;
            if (used_total < ID_COUNT) begin
                for (int idx = 0; idx < ID_COUNT; idx++) begin
                    if (!id_used[idx]) begin
                        id_used[idx] = 1'b1;
                        used_total++;
                        r.granted_id = ID_W'(base_now + idx);
                        r.status = ST_GRANTED;
                        break;
                    end
                end
            end
        end else begin
            // The offset wraps in 16 bits, so identifiers below the base land far out.
            offset = rel - base_now;
            if (offset < ID_COUNT) begin
                if (id_used[offset]) begin
                    id_used[offset] = 1'b0;
                    used_total--;
                end
                r.status = ST_RELEASED;
            end else begin
                r.status = ST_INVALID;
            end
        end
        return r;
    endfunction

    // Offers one request after a random gap and records what it must produce.
    task automatic offer_request(input logic mode, input logic [ID_W-1:0] id,
                                 input bit typed, input logic [ID_W-1:0] exp_id,
                                 input t_status exp_status);
        int      gap;
        t_result answer;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= id;
        do @(posedge i_clk); while (!o_s_axis_tready);
        answer = next_alloc_result(mode, id);
        if (typed) begin
            answer.granted_id = exp_id;
            answer.status = exp_status;
        end
        pending_results.push_back(answer);
    endtask

    // Stops offering and waits until every outstanding request has answered.
    task automatic idle_until_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // The base may only change while nothing is in flight.
    task automatic write_base_id(input logic [ID_W-1:0] value);
        idle_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        base_now = value;
    endtask

    // Mix of allocations, releases of likely-held identifiers, edge releases
    // and random noise, with one full drain halfway through.
    task automatic run_mixed_phase(input int n_items, input int alloc_pct);
        logic [ID_W-1:0] id;
        for (int n = 0; n < n_items; n++) begin
            if (n == n_items / 2) idle_until_drained();
            if ($urandom_range(0, 99) < alloc_pct) begin
                offer_request(MODE_ALLOC, ID_W'($urandom), 1'b0, '0, ST_GRANTED);
            end else begin
                case ($urandom_range(0, 9))
                    0: id = ID_W'($urandom);
                    1: begin
                        case ($urandom_range(0, 5))
                            0: id = ID_W'(base_now - 1);
                            1: id = base_now;
                            2: id = ID_W'(base_now + ID_COUNT - 1);
                            3: id = ID_W'(base_now + ID_COUNT);
                            4: id = '0;
                            default: id = '1;
                        endcase
                    end
                    // Allocation is lowest first, so held identifiers sit near the base.
                    default: id = ID_W'(base_now + $urandom_range(0, used_total + 8));
                endcase
                offer_request(MODE_RELEASE, id, 1'b0, '0, ST_GRANTED);
            end
        end
    endtask

    // Check each result against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result id %0d status %0d with no request pending",
                                          o_m_axis_tdata, o_m_axis_tuser));
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata !== want.granted_id)
                    report_mismatch($sformatf("granted_id %0d, expected %0d",
                                              o_m_axis_tdata, want.granted_id));
                if (o_m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_m_axis_tuser, want.status));
            end
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("bitmap_id_allocator test failed");
            $finish;
        end
    end

    // Result side: random stalls, and one long hold-off when asked for.
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_output) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end else begin
                gap = $urandom_range(0, rx_max_gap);
                if (gap > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Main sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset base of 300 and an empty map.
        directed_rows.push_back('{MODE_ALLOC,   16'h0000, 1'b1, 16'd300, ST_GRANTED});
        directed_rows.push_back('{MODE_ALLOC,   16'hFFFF, 1'b1, 16'd301, ST_GRANTED});
        directed_rows.push_back('{MODE_ALLOC,   16'hA5A5, 1'b1, 16'd302, ST_GRANTED});
        directed_rows.push_back('{MODE_RELEASE, 16'd300,  1'b1, 16'd0,   ST_RELEASED});
        directed_rows.push_back('{MODE_ALLOC,   16'h0000, 1'b1, 16'd300, ST_GRANTED});
        directed_rows.push_back('{MODE_RELEASE, 16'd299,  1'b1, 16'd0,   ST_INVALID});
        directed_rows.push_back('{MODE_RELEASE, 16'd4395, 1'b1, 16'd0,   ST_RELEASED});
        directed_rows.push_back('{MODE_RELEASE, 16'd4396, 1'b1, 16'd0,   ST_INVALID});
        directed_rows.push_back('{MODE_RELEASE, 16'h0000, 1'b1, 16'd0,   ST_INVALID});
        directed_rows.push_back('{MODE_RELEASE, 16'hFFFF, 1'b1, 16'd0,   ST_INVALID});
        directed_rows.push_back('{MODE_RELEASE, 16'd301,  1'b1, 16'd0,   ST_RELEASED});
        directed_rows.push_back('{MODE_RELEASE, 16'd301,  1'b1, 16'd0,   ST_RELEASED});
        directed_rows.push_back('{MODE_ALLOC,   16'h5A5A, 1'b1, 16'd301, ST_GRANTED});
        directed_rows.push_back('{MODE_ALLOC,   16'h0000, 1'b0, 16'd0,   ST_GRANTED});
        directed_rows.push_back('{MODE_RELEASE, 16'd302,  1'b0, 16'd0,   ST_GRANTED});
        directed_rows.push_back('{MODE_ALLOC,   16'h1234, 1'b0, 16'd0,   ST_GRANTED});
        directed_rows.push_back('{MODE_RELEASE, 16'h8000, 1'b0, 16'd0,   ST_GRANTED});
        directed_rows.push_back('{MODE_RELEASE, 16'h7FFF, 1'b0, 16'd0,   ST_GRANTED});
        foreach (directed_rows[r])
            offer_request(directed_rows[r].mode, directed_rows[r].id, directed_rows[r].typed,
                          directed_rows[r].exp_id, directed_rows[r].exp_status);

        // Lowest base; the receiver holds off at the start so the input backs up.
        write_base_id(16'd0);
        hold_output = 1'b1;
        run_mixed_phase(150, 65);

        // Highest base, both sides running without gaps.
        tx_max_gap = 0;
        rx_max_gap = 0;
        write_base_id(16'd61440);
        run_mixed_phase(150, 60);

        tx_max_gap = 13;
        write_base_id(ID_W'($urandom_range(0, 61440)));
        run_mixed_phase(150, 55);

        tx_max_gap = 0;
        rx_max_gap = 13;
        write_base_id(16'd5000);
        run_mixed_phase(150, 55);

        // Highest base again with random gaps on both sides.
        tx_max_gap = 13;
        rx_max_gap = 13;
        write_base_id(16'd61440);
        run_mixed_phase(150, 50);

        // Back to the reset base with releases dominating.
        write_base_id(BASE_RESET);
        run_mixed_phase(150, 35);

        idle_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("bitmap_id_allocator test passed");
        else
            $display("bitmap_id_allocator test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bia_pkg.sv
rtl/bitmap_id_allocator.sv
rtl/bia_checker.sv
sim/bitmap_id_allocator_tb.sv
